// ===== sv/tte_pkg.sv =====
// Shared types, action codes and constants for the transposition table engine.
// No dependencies; every other file imports this package.
`default_nettype none

package tte_pkg;

    localparam int TT_ENTRIES = 4096;
    localparam int TT_IDX_W   = $clog2(TT_ENTRIES);
    localparam int TT_CNT_W   = $clog2(TT_ENTRIES + 1);

    localparam logic [2:0] ACT_PROBE = 3'd0;
    localparam logic [2:0] ACT_FETCH = 3'd1;
    localparam logic [2:0] ACT_STORE = 3'd2;
    localparam logic [2:0] ACT_AGE   = 3'd3;
    localparam logic [2:0] ACT_COUNT = 3'd4;
    localparam logic [2:0] ACT_CLEAR = 3'd5;

    localparam logic signed [15:0] MATE_HIGH = 16'sd9000;
    localparam logic signed [15:0] MATE_LOW  = -16'sd9000;
    localparam logic [12:0]        COUNT_MAX = 13'd8191;

    typedef struct packed {
        logic [2:0]         action;
        logic [63:0]        search_key;
        logic [7:0]         want_depth;
        logic [7:0]         new_depth;
        logic signed [15:0] new_score;
        logic [7:0]         ply_from_root;
        logic [15:0]        best_move;
        logic [1:0]         bound_kind;
    } t_tte_in;

    typedef struct packed {
        logic               key_match;
        logic               depth_enough;
        logic [63:0]        stored_key;
        logic [15:0]        stored_move;
        logic signed [15:0] stored_score;
        logic [7:0]         stored_depth;
        logic [1:0]         stored_bound;
        logic [12:0]        live_count;
    } t_tte_out;

    typedef struct packed {
        logic [15:0]        move;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [1:0]         bound;
    } t_rec;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
        logic wipe;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/transposition_table_engine.sv =====
// Top level of the transposition table engine: controller plus datapath.
// Depends on tte_pkg, tte_ctrl and tte_dp.
//
// Command channel: an item in i_item is taken at a rising edge where start is
// high and busy is low. Each item gives exactly one result on o_result, shown
// for one cycle with o_done high; the receiver takes it in that cycle and
// cannot stall it.
// Probe, fetch, store, count and the unused codes: the slot is read from the key,
// record and age memories at the accepting edge and the read-modify-write
// completes in the next cycle; the result appears in the cycle after that, in
// which the next item may already be taken.
// Age all and clear all walk the table one slot per cycle through the single
// write port.
// The live count is kept in a running counter, so count costs no walk.
// Reset (synchronous, active low) starts a clearing pass over all TT_ENTRIES
// slots with busy high and no result; items are taken once busy falls.
`default_nettype none

module transposition_table_engine (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  tte_pkg::t_tte_in  i_item,
    output logic              busy,
    output logic              o_done,
    output tte_pkg::t_tte_out o_result
);
    import tte_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    tte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    tte_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_item),
        .o_stat   (dp_stat),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

`default_nettype wire

// ===== sv/tte_ctrl.sv =====
// Controller for the transposition table engine: accept, single-slot op and sweeps.
// Depends on tte_pkg; drives tte_dp through t_dp_cmd.
`default_nettype none

module tte_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire [2:0]         i_action,
    input  tte_pkg::t_dp_stat i_stat,
    output tte_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import tte_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_OP,
        S_SWEEP
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy, n_busy;
    logic    r_wipe, n_wipe;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_wipe  = r_wipe;
        cmd     = '0;
        unique case (r_state)
            S_INIT: begin
                cmd.sweep = 1'b1;
                cmd.wipe  = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_busy   = 1'b1;
                    if (i_action == ACT_AGE || i_action == ACT_CLEAR) begin
                        n_state = S_SWEEP;
                        n_wipe  = (i_action == ACT_CLEAR);
                    end else begin
                        n_state = S_OP;
                    end
                end
            end
            S_OP: begin
                cmd.exec = 1'b1;
                cmd.emit = 1'b1;
                n_state  = S_IDLE;
                n_busy   = 1'b0;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                cmd.wipe  = r_wipe;
                if (i_stat.sweep_last) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                    n_busy   = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_busy  <= 1'b1;
            r_wipe  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_wipe  <= n_wipe;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ===== sv/tte_dp.sv =====
// Datapath for the transposition table engine: key, record and age memories,
// live counter, mate score adjust and result register. Depends on tte_pkg.
`default_nettype none

module tte_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tte_pkg::t_dp_cmd  i_cmd,
    input  tte_pkg::t_tte_in  i_item,
    output tte_pkg::t_dp_stat o_stat,
    output tte_pkg::t_tte_out o_result,
    output logic              o_done
);
    import tte_pkg::*;

    logic [63:0] mem_key [TT_ENTRIES];
    t_rec        mem_rec [TT_ENTRIES];
    logic        mem_anc [TT_ENTRIES];

    t_tte_in               r_item;
    logic [63:0]           r_rd_key;
    t_rec                  r_rd_rec;
    logic                  r_rd_anc;
    logic [TT_IDX_W-1:0]   r_sweep_addr, n_sweep_addr;
    logic [TT_CNT_W-1:0]   r_live, n_live;
    t_tte_out              r_result, n_result;
    logic                  r_done;

    logic [TT_IDX_W-1:0]   rd_addr, wr_addr;
    logic                  key_we, rec_we, anc_we;
    logic [63:0]           key_wdata;
    t_rec                  rec_wdata;
    logic                  anc_wdata;
    logic                  sweep_last;
    logic                  key_hit, write_ok;
    logic signed [16:0]    score_ext, ply_ext, score_sum;
    logic signed [15:0]    adj_score;
    logic [31:0]           live_wide;

    assign rd_addr    = i_item.search_key[TT_IDX_W-1:0];
    assign sweep_last = (r_sweep_addr == TT_IDX_W'(TT_ENTRIES - 1));

    always_comb begin
        score_ext = {r_item.new_score[15], r_item.new_score};
        ply_ext   = {9'd0, r_item.ply_from_root};
        score_sum = score_ext;
        adj_score = r_item.new_score;
        if (r_item.new_score > MATE_HIGH) begin
            score_sum = score_ext + ply_ext;
            adj_score = (score_sum > 17'sd32767) ? 16'sh7FFF : score_sum[15:0];
        end else if (r_item.new_score < MATE_LOW) begin
            score_sum = score_ext - ply_ext;
            adj_score = (score_sum < -17'sd32768) ? 16'sh8000 : score_sum[15:0];
        end
    end

    assign key_hit   = (r_rd_key == r_item.search_key);
    assign write_ok  = (r_rd_key == 64'd0) || (r_rd_rec.depth <= r_item.new_depth) || r_rd_anc;
    assign live_wide = 32'(r_live);

    always_comb begin
        key_we       = 1'b0;
        rec_we       = 1'b0;
        anc_we       = 1'b0;
        wr_addr      = r_item.search_key[TT_IDX_W-1:0];
        key_wdata    = r_item.search_key;
        rec_wdata    = '{move: r_item.best_move, score: adj_score,
                         depth: r_item.new_depth, bound: r_item.bound_kind};
        anc_wdata    = 1'b0;
        n_sweep_addr = r_sweep_addr;
        n_live       = r_live;
        n_result     = '0;
        if (i_cmd.sweep) begin
            wr_addr      = r_sweep_addr;
            anc_we       = 1'b1;
            n_sweep_addr = sweep_last ? '0 : r_sweep_addr + TT_IDX_W'(1);
            if (i_cmd.wipe) begin
                key_we    = 1'b1;
                rec_we    = 1'b1;
                key_wdata = '0;
                rec_wdata = '0;
            end else begin
                anc_wdata = 1'b1;
            end
            if (sweep_last) begin
                n_live = i_cmd.wipe ? TT_CNT_W'(TT_ENTRIES) : '0;
            end
        end else if (i_cmd.exec) begin
            case (r_item.action)
                ACT_PROBE, ACT_FETCH: begin
                    n_result.key_match    = key_hit;
                    n_result.depth_enough = key_hit && (r_rd_rec.depth >= r_item.want_depth);
                    if (r_item.action == ACT_FETCH) begin
                        n_result.stored_key   = r_rd_key;
                        n_result.stored_move  = r_rd_rec.move;
                        n_result.stored_score = r_rd_rec.score;
                        n_result.stored_depth = r_rd_rec.depth;
                        n_result.stored_bound = r_rd_rec.bound;
                        anc_we = 1'b1;
                        if (r_rd_anc) begin
                            n_live = r_live + TT_CNT_W'(1);
                        end
                    end
                end
                ACT_STORE: begin
                    if (write_ok) begin
                        key_we = 1'b1;
                        rec_we = 1'b1;
                        anc_we = 1'b1;
                        if (r_rd_anc) begin
                            n_live = r_live + TT_CNT_W'(1);
                        end
                    end
                end
                ACT_COUNT: begin
                    n_result.live_count = (live_wide > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                       : 13'(live_wide);
                end
                default: begin
                    n_result = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_key[wr_addr] <= key_wdata;
        end
        if (i_cmd.load) begin
            r_rd_key <= mem_key[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            mem_rec[wr_addr] <= rec_wdata;
        end
        if (i_cmd.load) begin
            r_rd_rec <= mem_rec[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            mem_anc[wr_addr] <= anc_wdata;
        end
        if (i_cmd.load) begin
            r_rd_anc <= mem_anc[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_live       <= '0;
            r_done       <= 1'b0;
        end else begin
            r_sweep_addr <= n_sweep_addr;
            r_live       <= n_live;
            r_done       <= i_cmd.emit;
        end
    end

    assign o_stat.sweep_last = sweep_last;
    assign o_result          = r_result;
    assign o_done            = r_done;

endmodule

`default_nettype wire

// ===== sv/tte_chk.sv =====
// Port-level checker for the transposition table engine, bound to the top level.
// Depends on tte_pkg.
`default_nettype none

module tte_chk (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               start,
    input wire               busy,
    input wire               o_done,
    input tte_pkg::t_tte_in  i_item,
    input tte_pkg::t_tte_out o_result
);
    import tte_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted beat");

    a_short_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action != ACT_AGE && i_item.action != ACT_CLEAR)
        |-> ##2 o_done)
        else $error("single-slot beat did not complete in two cycles");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_depth_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.depth_enough && !o_result.key_match))
        else $error("depth_enough without key_match");

endmodule

bind transposition_table_engine tte_chk u_tte_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .i_item   (i_item),
    .o_result (o_result)
);

`default_nettype wire
